// ===== hw/rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared definitions for the circular deque
// Sizes, command/status/mode codes and the per-cell control struct.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH  = 8;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int WORD_W = 32;
	localparam int OCC_W  = 4;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [1:0]               code_t;

	// commands
	localparam code_t CMD_PUSH_REAR  = 2'd0;
	localparam code_t CMD_PUSH_FRONT = 2'd1;
	localparam code_t CMD_POP_FRONT  = 2'd2;
	localparam code_t CMD_POP_REAR   = 2'd3;

	// status
	localparam code_t ST_OK        = 2'd0;
	localparam code_t ST_OVERFLOW  = 2'd1;
	localparam code_t ST_UNDERFLOW = 2'd2;
	localparam code_t ST_DENIED    = 2'd3;

	// restriction modes
	localparam code_t MODE_FREE       = 2'd0;
	localparam code_t MODE_NO_FPUSH   = 2'd1;
	localparam code_t MODE_NO_RPOP    = 2'd2;

	// per-cell control for one cycle
	typedef struct packed {
		logic load;       // take the pushed word
		logic from_front; // take the front neighbor's word (shift toward rear)
		logic from_rear;  // take the rear neighbor's word (shift toward front)
	} cell_ctl_t;

endpackage

// ===== hw/rtl/cdq_if.sv =====
// ----------------------------------------------------------------------------
// cdq channel interfaces
// Command, result and mode-register channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface cdq_cmd_if;
	import cdq_pkg::*;
	logic  valid;
	logic  ready;
	code_t cmd;
	word_t push_value;
	modport source (output valid, output cmd, output push_value, input ready);
	modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface cdq_rsp_if;
	import cdq_pkg::*;
	logic             valid;
	logic             ready;
	code_t            status;
	word_t            popped_value;
	logic [OCC_W-1:0] occupancy;
	modport source (output valid, output status, output popped_value, output occupancy,
		input ready);
	modport sink   (input valid, input status, input popped_value, input occupancy,
		output ready);
endinterface

interface cdq_cfg_if;
	import cdq_pkg::*;
	logic  valid;
	logic  ready;
	code_t restrict_mode;
	modport source (output valid, output restrict_mode, input ready);
	modport sink   (input valid, input restrict_mode, output ready);
endinterface

// ===== hw/rtl/circular_deque_unit.sv =====
// ----------------------------------------------------------------------------
// circular_deque_unit: double-ended queue of signed words
// Row of cells with cell 0 at the front; front pushes and pops shift the row.
// ----------------------------------------------------------------------------
// A result is registered and valid in the cycle after its command is accepted.
// Throughput: one command per cycle while results are taken as they appear;
//   the single result register sets this, ready drops only while it is held.
// Reset: queue empty, mode unrestricted; stored words are not cleared.
// Mode writes are taken in any cycle (cfg ready is always high).
module circular_deque_unit import cdq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cdq_cmd_if.sink    command,
	cdq_rsp_if.source  result,
	cdq_cfg_if.sink    cfg
);

	cnt_t             count_q;
	code_t            mode_q;
	logic             out_valid_q;
	code_t            status_q;
	word_t            popped_q;
	logic [OCC_W-1:0] occ_q;

	word_t     cell_word [DEPTH];
	cell_ctl_t cell_ctl  [DEPTH];

	logic             accept;
	logic             is_push;
	logic             denied;
	code_t            status_c;
	logic             do_op;
	cnt_t             rear_sel;
	cnt_t             count_next;
	word_t            popped_c;

	assign command.ready = !out_valid_q || result.ready;
	assign cfg.ready     = 1'b1;
	assign accept        = command.valid && command.ready;

	assign is_push = (command.cmd == CMD_PUSH_REAR) || (command.cmd == CMD_PUSH_FRONT);
	assign denied  = (mode_q == MODE_NO_FPUSH && command.cmd == CMD_PUSH_FRONT) ||
	                 (mode_q == MODE_NO_RPOP  && command.cmd == CMD_POP_REAR);

	always_comb begin
		if (denied) begin
			status_c = ST_DENIED;
		end else if (is_push && count_q == cnt_t'(DEPTH)) begin
			status_c = ST_OVERFLOW;
		end else if (!is_push && count_q == '0) begin
			status_c = ST_UNDERFLOW;
		end else begin
			status_c = ST_OK;
		end
	end

	assign do_op    = accept && (status_c == ST_OK);
	assign rear_sel = count_q - cnt_t'(1);

	always_comb begin
		popped_c   = '0;
		count_next = count_q;
		if (status_c == ST_OK) begin
			case (command.cmd)
				CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
					count_next = count_q + cnt_t'(1);
				end
				CMD_POP_FRONT: begin
					popped_c   = cell_word[0];
					count_next = count_q - cnt_t'(1);
				end
				CMD_POP_REAR: begin
					popped_c   = cell_word[rear_sel[IDX_W-1:0]];
					count_next = count_q - cnt_t'(1);
				end
				default: begin
					count_next = count_q;
				end
			endcase
		end
	end

	// per-cell controls: front push shifts the row toward the rear,
	// front pop shifts it toward the front, rear ops touch no neighbors
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i].load = do_op &&
				((command.cmd == CMD_PUSH_REAR && count_q == cnt_t'(i)) ||
				 (command.cmd == CMD_PUSH_FRONT && i == 0));
			cell_ctl[i].from_front = do_op && command.cmd == CMD_PUSH_FRONT && i != 0;
			cell_ctl[i].from_rear  = do_op && command.cmd == CMD_POP_FRONT;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		word_t front_w;
		word_t rear_w;
		if (g == 0) begin : g_first
			assign front_w = command.push_value;
		end else begin : g_mid_f
			assign front_w = cell_word[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign rear_w = '0;
		end else begin : g_mid_r
			assign rear_w = cell_word[g+1];
		end
		cdq_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[g]),
			.push_value (command.push_value),
			.front_word (front_w),
			.rear_word  (rear_w),
			.word_q     (cell_word[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			mode_q      <= MODE_FREE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				mode_q <= cfg.restrict_mode;
			end
			if (do_op) begin
				count_q <= count_next;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_c;
			popped_q <= popped_c;
			occ_q    <= OCC_W'(count_next);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = status_q;
	assign result.popped_value = popped_q;
	assign result.occupancy    = occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(DEPTH))
		else $error("entry count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_c == ST_OK && is_push) |=> count_q == cnt_t'($past(count_q) + 1'b1))
		else $error("accepted push did not grow the queue");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_c != ST_OK) |=> $stable(count_q))
		else $error("rejected command changed the queue");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(accept))
		else $error("result appeared without an accepted command");

	a_occ_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept) |=> occ_q == OCC_W'(count_q))
		else $error("reported occupancy differs from entry count");

endmodule

// ===== hw/rtl/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell: one storage slot of the deque row
// Holds one word; loads the pushed word or a neighbor's word on command.
// ----------------------------------------------------------------------------
module cdq_cell import cdq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  word_t     push_value,
	input  word_t     front_word,
	input  word_t     rear_word,
	output word_t     word_q
);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= push_value;
		end else if (ctl.from_front) begin
			word_q <= front_word;
		end else if (ctl.from_rear) begin
			word_q <= rear_word;
		end
	end

endmodule

// ===== bench/circular_deque_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_unit_test: self-checking bench for the circular deque
// Drives commands and mode writes over the valid/ready channels and mirrors
// the deque in a local model. Every result word is checked in order: typed
// values for the directed rows that pin one, the model for all the rest.
// ----------------------------------------------------------------------------
module circular_deque_unit_test;
	import cdq_pkg::*;

	localparam code_t MODE_SPARE   = 2'd3;
	localparam int    SCRIPT_ROWS  = 25;
	localparam int    PHASES       = 8;
	localparam int    PHASE_ITEMS  = 250;
	localparam int    IDLE_PCT     = 13;
	localparam int    STALL_LIMIT  = 1000;

	typedef struct packed {
		code_t            status;
		word_t            popped;
		logic [OCC_W-1:0] occ;
	} outcome_t;

	typedef struct packed {
		logic     on;
		outcome_t want;
	} pin_t;

	typedef struct packed {
		code_t    mode;
		code_t    op;
		word_t    value;
		logic     pinned;
		outcome_t want;
	} row_t;

	logic clk;
	logic arst_n;

	cdq_cmd_if command();
	cdq_rsp_if result();
	cdq_cfg_if cfg();

	circular_deque_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.command(command),
		.result (result),
		.cfg    (cfg)
	);

	// local mirror of the deque
	word_t mirror_words [DEPTH];
	int    mirror_head;
	int    mirror_tail;
	int    mirror_count;
	code_t mirror_mode;

	outcome_t pending_results [$];
	pin_t     pinned_results [$];
	row_t     script [SCRIPT_ROWS];

	int  mismatches;
	int  commands_taken;
	int  mode_writes;
	int  status_seen [4];
	int  quiet_cycles;
	bit  calm;
	outcome_t want;
	outcome_t got;
	pin_t     pin;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic outcome_t predict_outcome(code_t op, word_t value);
		outcome_t r;
		bit is_push;
		r.status = ST_OK;
		r.popped = '0;
		is_push = (op == CMD_PUSH_REAR) || (op == CMD_PUSH_FRONT);
		if ((mirror_mode == MODE_NO_FPUSH && op == CMD_PUSH_FRONT) ||
				(mirror_mode == MODE_NO_RPOP && op == CMD_POP_REAR)) begin
			r.status = ST_DENIED;
		end else if (is_push && mirror_count >= DEPTH) begin
			r.status = ST_OVERFLOW;
		end else if (!is_push && mirror_count == 0) begin
			r.status = ST_UNDERFLOW;
		end else begin
			case (op)
				CMD_PUSH_REAR: begin
					mirror_words[mirror_tail] = value;
					mirror_tail = (mirror_tail + 1) % DEPTH;
					mirror_count++;
				end
				CMD_PUSH_FRONT: begin
					mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
					mirror_words[mirror_head] = value;
					mirror_count++;
				end
				CMD_POP_FRONT: begin
					r.popped = mirror_words[mirror_head];
					mirror_head = (mirror_head + 1) % DEPTH;
					mirror_count--;
				end
				default: begin
					mirror_tail = (mirror_tail + DEPTH - 1) % DEPTH;
					r.popped = mirror_words[mirror_tail];
					mirror_count--;
				end
			endcase
		end
		r.occ = mirror_count[OCC_W-1:0];
		return r;
	endfunction

	task automatic report(string what, logic [31:0] seen, logic [31:0] wanted);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, seen, wanted);
		mismatches++;
	endtask

	function automatic bit take_break();
		return !calm && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	function automatic word_t pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return word_t'($urandom);
		endcase
	endfunction

	// Call at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(code_t op, word_t value, pin_t p);
		while (take_break()) begin
			command.valid <= 1'b0;
			@(negedge clk);
		end
		pinned_results.push_back(p);
		command.valid      <= 1'b1;
		command.cmd        <= op;
		command.push_value <= value;
		@(posedge clk);
		while (!command.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold off the sender until every outstanding result has come back.
	task automatic wait_drained();
		command.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_mode(code_t mode);
		cfg.valid         <= 1'b1;
		cfg.restrict_mode <= mode;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		mode_writes++;
	endtask

	always @(negedge clk)
		result.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

	// Check results, predict on every accepted command, track mode writes.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (result.valid && result.ready) begin
				quiet_cycles = 0;
				if (pending_results.size() == 0) begin
					report("result with no command pending", {30'd0, result.status}, '0);
				end else begin
					want = pending_results.pop_front();
					if (result.status !== want.status)
						report("status", {30'd0, result.status}, {30'd0, want.status});
					if (result.popped_value !== want.popped)
						report("popped_value", result.popped_value, want.popped);
					if (result.occupancy !== want.occ)
						report("occupancy", {28'd0, result.occupancy}, {28'd0, want.occ});
				end
			end
			if (command.valid && command.ready) begin
				quiet_cycles = 0;
				got = predict_outcome(command.cmd, command.push_value);
				pin = pinned_results.pop_front();
				if (pin.on)
					got = pin.want;
				status_seen[got.status]++;
				commands_taken++;
				pending_results.push_back(got);
			end
			if (cfg.valid && cfg.ready) begin
				quiet_cycles = 0;
				mirror_mode = cfg.restrict_mode;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("circular_deque_unit_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int   push_pct;
		code_t op;
		pin_t  no_pin;

		clk                = 1'b0;
		arst_n             = 1'b0;
		command.valid      = 1'b0;
		command.cmd        = CMD_PUSH_REAR;
		command.push_value = '0;
		cfg.valid          = 1'b0;
		cfg.restrict_mode  = MODE_FREE;
		result.ready       = 1'b0;
		calm               = 1'b0;
		mismatches         = 0;
		commands_taken     = 0;
		mode_writes        = 0;
		quiet_cycles       = 0;
		status_seen        = '{default: 0};
		no_pin             = '0;

		mirror_head  = 0;
		mirror_tail  = 0;
		mirror_count = 0;
		mirror_mode  = MODE_FREE;
		foreach (mirror_words[i])
			mirror_words[i] = '0;

		script = '{
			'{MODE_FREE, CMD_POP_FRONT, 32'h0, 1'b1, '{ST_UNDERFLOW, 32'h0, 4'd0}},
			'{MODE_FREE, CMD_POP_REAR, 32'h0, 1'b1, '{ST_UNDERFLOW, 32'h0, 4'd0}},
			'{MODE_FREE, CMD_PUSH_REAR, 32'h7FFF_FFFF, 1'b1, '{ST_OK, 32'h0, 4'd1}},
			'{MODE_FREE, CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, '{ST_OK, 32'h0, 4'd2}},
			'{MODE_FREE, CMD_PUSH_REAR, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 4'd3}},
			'{MODE_FREE, CMD_PUSH_FRONT, 32'h0, 1'b1, '{ST_OK, 32'h0, 4'd4}},
			'{MODE_FREE, CMD_PUSH_REAR, 32'h1234_5678, 1'b0, '0},
			'{MODE_FREE, CMD_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, '0},
			'{MODE_FREE, CMD_PUSH_REAR, 32'h5A5A_5A5A, 1'b0, '0},
			'{MODE_FREE, CMD_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
			// full at both ends
			'{MODE_FREE, CMD_PUSH_REAR, 32'hDEAD_BEEF, 1'b1, '{ST_OVERFLOW, 32'h0, 4'd8}},
			'{MODE_FREE, CMD_PUSH_FRONT, 32'hDEAD_BEEF, 1'b1, '{ST_OVERFLOW, 32'h0, 4'd8}},
			'{MODE_FREE, CMD_POP_REAR, 32'h0, 1'b0, '0},
			'{MODE_FREE, CMD_POP_FRONT, 32'h0, 1'b0, '0},
			'{MODE_FREE, CMD_POP_REAR, 32'h0, 1'b0, '0},
			'{MODE_FREE, CMD_POP_FRONT, 32'h0, 1'b0, '0},
			'{MODE_NO_FPUSH, CMD_PUSH_FRONT, 32'h1, 1'b1, '{ST_DENIED, 32'h0, 4'd4}},
			'{MODE_NO_FPUSH, CMD_POP_REAR, 32'h0, 1'b0, '0},
			'{MODE_NO_FPUSH, CMD_PUSH_REAR, 32'h0F0F_0F0F, 1'b0, '0},
			'{MODE_NO_RPOP, CMD_POP_REAR, 32'h0, 1'b1, '{ST_DENIED, 32'h0, 4'd4}},
			'{MODE_NO_RPOP, CMD_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, '0},
			'{MODE_NO_RPOP, CMD_POP_FRONT, 32'h0, 1'b0, '0},
			// unused mode code behaves as unrestricted
			'{MODE_SPARE, CMD_POP_REAR, 32'h0, 1'b0, '0},
			'{MODE_SPARE, CMD_PUSH_FRONT, 32'h3C3C_3C3C, 1'b0, '0},
			'{MODE_SPARE, CMD_POP_FRONT, 32'h0, 1'b0, '0}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			if (i == 0 || script[i].mode != script[i-1].mode) begin
				wait_drained();
				write_mode(script[i].mode);
			end
			send_word(script[i].op, script[i].value, '{script[i].pinned, script[i].want});
		end

		// Random phases; the first four walk every mode code, the rest pick at random.
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_mode(ph < 4 ? code_t'(ph) : code_t'($urandom_range(0, 3)));
			calm = (ph == 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// swing between filling and draining so both ends wrap and saturate
				if (n % 12 == 0)
					push_pct = $urandom_range(0, 1) ? 75 : 25;
				if ($urandom_range(0, 99) < push_pct)
					op = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
				else
					op = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
				send_word(op, pick_value(), no_pin);
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (4) @(posedge clk);

		$display("covered %0d commands over %0d mode writes", commands_taken, mode_writes);
		$display("status ok %0d, overflow %0d, underflow %0d, denied %0d",
			status_seen[ST_OK], status_seen[ST_OVERFLOW],
			status_seen[ST_UNDERFLOW], status_seen[ST_DENIED]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("circular_deque_unit_test: PASS");
		end else begin
			$display("circular_deque_unit_test: FAIL");
		end
		$finish;
	end

endmodule

// ===== circular_deque_unit.f =====
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_if.sv
hw/rtl/cdq_cell.sv
hw/rtl/circular_deque_unit.sv
bench/circular_deque_unit_test.sv
